### rtl/matrix_column_and_antidiagonal_reduce_macros.svh
// assertion macros for the column and anti-diagonal reduce block
// used by the top level; expects clk and rst_n in scope
`ifndef MATRIX_COLUMN_AND_ANTIDIAGONAL_REDUCE_MACROS_SVH
`define MATRIX_COLUMN_AND_ANTIDIAGONAL_REDUCE_MACROS_SVH

// same-cycle implication
`define MCAR_ASSERT_IMPLY(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("mcar assertion failed");

// next-cycle implication
`define MCAR_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mcar assertion failed");

`endif

### rtl/mcar_pkg.sv
// shared constants for the column and anti-diagonal reduce block
// no dependencies
package mcar_pkg;

    localparam int CFG_W      = 7;
    localparam int TOTAL_W    = 27;
    localparam int MIN_W      = 22;
    localparam int SIZE_CMP_W = 9;
    localparam int RESET_SIZE = 4;

endpackage

### rtl/matrix_column_and_antidiagonal_reduce.sv
// top level of the column and anti-diagonal reduce block
// depends on mcar_pkg, mcar_ram and matrix_column_and_antidiagonal_reduce_macros.svh
//
// Matrix elements enter on the input channel (in_valid, in_stall, element_value),
// one beat per element in row-major order. After the last element of an n-by-n
// matrix one result beat leaves on the output channel (out_valid, out_stall,
// nonneg_column_total, min_antidiagonal_sum); the next matrix starts at once.
// matrix_size is written through cfg_valid/cfg_ready while the block is idle;
// a write restarts the matrix in progress. 0 acts as 1, sizes above MAX_SIZE
// act as MAX_SIZE.
// Throughput: one element per cycle while in_stall is low. Each element does one
// read-modify-write of a column ram entry and one of an anti-diagonal ram entry;
// a two-stage pipe (ram read, then update and write back) with write-to-read
// forwarding keeps that at one element per clock.
// The result is registered: out_valid rises when stage 1 writes the last
// element's result into the output register.
// A stalled result is held in the output register; elements keep flowing until
// the next matrix's last element finds that register still full and stalled.
// Reset: counters and running total clear, running minimum goes to all ones,
// size goes to 4. The rams need no clearing: every entry is written before
// it is read within a matrix.
`include "matrix_column_and_antidiagonal_reduce_macros.svh"

module matrix_column_and_antidiagonal_reduce #(
    parameter int MAX_SIZE      = 64,
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [ELEMENT_WIDTH-1:0]   element_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mcar_pkg::TOTAL_W-1:0]      nonneg_column_total,
    output logic [mcar_pkg::MIN_W-1:0]        min_antidiagonal_sum,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mcar_pkg::CFG_W-1:0]        matrix_size
);

    localparam int IDX_W      = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int DIAG_DEPTH = 2 * MAX_SIZE - 1;
    localparam int DIAG_AW    = (DIAG_DEPTH > 1) ? $clog2(DIAG_DEPTH) : 1;
    localparam int COL_W      = ELEMENT_WIDTH + IDX_W + 1;
    localparam int DIAG_W     = ELEMENT_WIDTH + IDX_W;
    localparam int TOT_W      = COL_W + IDX_W;
    localparam int MIN_W      = mcar_pkg::MIN_W;
    localparam int SZ_W       = mcar_pkg::SIZE_CMP_W;
    localparam logic [IDX_W-1:0] RESET_LAST = IDX_W'(
        ((mcar_pkg::RESET_SIZE > MAX_SIZE) ? MAX_SIZE : mcar_pkg::RESET_SIZE) - 1);

    // configuration
    logic             cfg_acc;
    logic [SZ_W-1:0]  size_wide;
    logic [IDX_W-1:0] size_last_next;
    logic [IDX_W-1:0] size_last_reg;

    // stage 0 counters
    logic [IDX_W-1:0]   row_reg;
    logic [IDX_W-1:0]   col_reg;
    logic [IDX_W-1:0]   row_next;
    logic [IDX_W-1:0]   col_next;
    logic               row_first0;
    logic               row_last0;
    logic               col_first0;
    logic               col_last0;
    logic [DIAG_AW-1:0] diag_addr0;
    logic               accept;

    // stage 1
    logic                            s1_valid_reg;
    logic signed [ELEMENT_WIDTH-1:0] s1_value_reg;
    logic [IDX_W-1:0]                s1_col_reg;
    logic [DIAG_AW-1:0]              s1_diag_reg;
    logic                            s1_row_first_reg;
    logic                            s1_row_last_reg;
    logic                            s1_col_first_reg;
    logic                            s1_col_last_reg;
    logic                            s1_go;
    logic                            s1_wr;
    logic                            elem_last;

    // forwarding
    logic              col_fwd_hit_reg;
    logic [COL_W:0]    col_fwd_reg;
    logic              diag_fwd_hit_reg;
    logic [DIAG_W-1:0] diag_fwd_reg;

    // update datapath
    logic [COL_W:0]             col_rdata;
    logic [COL_W:0]             col_old;
    logic [DIAG_W-1:0]          diag_rdata;
    logic [DIAG_W-1:0]          diag_old;
    logic [COL_W-1:0]           v_ext;
    logic                       v_neg;
    logic [ELEMENT_WIDTH-1:0]   mag;
    logic [COL_W-1:0]           acc_new;
    logic                       neg_new;
    logic [COL_W:0]             col_wdata;
    logic [DIAG_W-1:0]          diag_new;
    logic [TOT_W-1:0]           total_add;
    logic [TOT_W-1:0]           total_sum;
    logic [MIN_W-1:0]           min_cand;
    logic [MIN_W-1:0]           min_upd;
    logic [TOT_W-1:0]           total_reg;
    logic [MIN_W-1:0]           min_reg;

    // output register
    logic                          out_valid_reg;
    logic [mcar_pkg::TOTAL_W-1:0]  out_total_reg;
    logic [MIN_W-1:0]              out_min_reg;

    assign cfg_ready = !s1_valid_reg;
    assign cfg_acc   = cfg_valid && cfg_ready;

    always_comb
    begin
        size_wide = SZ_W'(matrix_size);
        if (size_wide == '0)
        begin
            size_last_next = '0;
        end
        else if (size_wide > SZ_W'(MAX_SIZE))
        begin
            size_last_next = IDX_W'(MAX_SIZE - 1);
        end
        else
        begin
            size_last_next = IDX_W'(size_wide - SZ_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_last_reg <= RESET_LAST;
        end
        else if (cfg_acc)
        begin
            size_last_reg <= size_last_next;
        end
    end

    // stage 0: position of the incoming element
    assign row_first0 = (row_reg == '0);
    assign col_first0 = (col_reg == '0);
    assign row_last0  = (row_reg == size_last_reg);
    assign col_last0  = (col_reg == size_last_reg);
    assign diag_addr0 = DIAG_AW'(row_reg) + DIAG_AW'(col_reg);

    always_comb
    begin
        row_next = row_reg;
        col_next = IDX_W'(col_reg + 1'b1);
        if (col_last0)
        begin
            col_next = '0;
            row_next = row_last0 ? '0 : IDX_W'(row_reg + 1'b1);
        end
    end

    assign elem_last = s1_row_last_reg && s1_col_last_reg;
    assign s1_go     = !(s1_valid_reg && elem_last && out_valid_reg && out_stall);
    assign s1_wr     = s1_valid_reg && s1_go;
    assign accept    = in_valid && s1_go;
    assign in_stall  = !s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cfg_acc)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= accept;
        end
    end

    // stage 1 payload and forwarding from the write in flight
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg     <= element_value;
            s1_col_reg       <= col_reg;
            s1_diag_reg      <= diag_addr0;
            s1_row_first_reg <= row_first0;
            s1_row_last_reg  <= row_last0;
            s1_col_first_reg <= col_first0;
            s1_col_last_reg  <= col_last0;
            col_fwd_hit_reg  <= s1_wr && (s1_col_reg == col_reg);
            col_fwd_reg      <= col_wdata;
            diag_fwd_hit_reg <= s1_wr && (s1_diag_reg == diag_addr0);
            diag_fwd_reg     <= diag_new;
        end
    end

    mcar_ram #(
        .WIDTH (COL_W + 1),
        .DEPTH (MAX_SIZE)
    ) u_col_ram (
        .clk   (clk),
        .we    (s1_wr),
        .waddr (s1_col_reg),
        .wdata (col_wdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (col_rdata)
    );

    mcar_ram #(
        .WIDTH (DIAG_W),
        .DEPTH (DIAG_DEPTH)
    ) u_diag_ram (
        .clk   (clk),
        .we    (s1_wr),
        .waddr (s1_diag_reg),
        .wdata (diag_new),
        .re    (accept),
        .raddr (diag_addr0),
        .rdata (diag_rdata)
    );

    // stage 1: read-modify-write
    always_comb
    begin
        col_old  = col_fwd_hit_reg ? col_fwd_reg : col_rdata;
        diag_old = diag_fwd_hit_reg ? diag_fwd_reg : diag_rdata;
        v_ext    = COL_W'(s1_value_reg);
        v_neg    = s1_value_reg[ELEMENT_WIDTH-1];
        mag      = v_neg ? ELEMENT_WIDTH'(-s1_value_reg) : ELEMENT_WIDTH'(s1_value_reg);

        if (s1_row_first_reg)
        begin
            acc_new = v_ext;
            neg_new = v_neg;
        end
        else
        begin
            acc_new = col_old[COL_W-1:0] + v_ext;
            neg_new = col_old[COL_W] | v_neg;
        end
        col_wdata = {neg_new, acc_new};

        if (s1_row_first_reg || s1_col_last_reg)
        begin
            diag_new = DIAG_W'(mag);
        end
        else
        begin
            diag_new = diag_old + DIAG_W'(mag);
        end

        total_add = (s1_row_last_reg && !neg_new) ? TOT_W'(acc_new) : '0;
        total_sum = total_reg + total_add;

        min_cand = MIN_W'(diag_new);
        min_upd  = min_reg;
        if ((s1_col_first_reg || s1_row_last_reg) && (min_cand < min_reg))
        begin
            min_upd = min_cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            min_reg   <= '1;
        end
        else if (cfg_acc)
        begin
            total_reg <= '0;
            min_reg   <= '1;
        end
        else if (s1_wr)
        begin
            if (elem_last)
            begin
                total_reg <= '0;
                min_reg   <= '1;
            end
            else
            begin
                total_reg <= total_sum;
                min_reg   <= min_upd;
            end
        end
    end

    // result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_wr && elem_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_wr && elem_last)
        begin
            out_total_reg <= mcar_pkg::TOTAL_W'(total_sum);
            out_min_reg   <= min_upd;
        end
    end

    assign out_valid            = out_valid_reg;
    assign nonneg_column_total  = out_total_reg;
    assign min_antidiagonal_sum = out_min_reg;

    `MCAR_ASSERT_IMPLY(a_stall_only_on_full_output, in_stall, out_valid_reg && out_stall)
    `MCAR_ASSERT_NEXT(a_cfg_restarts, cfg_acc, row_reg == '0 && col_reg == '0 && total_reg == '0)
    `MCAR_ASSERT_IMPLY(a_result_from_last_element, $rose(out_valid_reg), $past(s1_valid_reg && elem_last))
    `MCAR_ASSERT_IMPLY(a_counters_in_range, 1'b1, row_reg <= size_last_reg && col_reg <= size_last_reg)

endmodule

### rtl/mcar_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mcar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### tb/sv/tb_matrix_column_and_antidiagonal_reduce.sv
// self-checking testbench for matrix_column_and_antidiagonal_reduce
// streams directed and random matrices through the block and checks each result beat
// against a cycle-free predictor; depends on mcar_pkg and the rtl top level
module tb_matrix_column_and_antidiagonal_reduce;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_N        = 64;
    localparam int ELEM_W       = 16;
    localparam int DIAG_N       = 2 * MAX_N - 1;
    localparam int RANDOM_ITEMS = 1600;
    localparam int OVERSIZE_ITEMS = 3 * MAX_N;
    localparam int PIPE_LATENCY = 6;
    localparam int IDLE_LIMIT   = 4000;
    localparam int REPORT_MAX   = 10;

    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef struct packed {
        logic [mcar_pkg::TOTAL_W-1:0] total;
        logic [mcar_pkg::MIN_W-1:0]   min_sum;
    } reduce_result_t;

    typedef enum int {
        VAL_NONNEG,
        VAL_SPARSE_NEG,
        VAL_ANY,
        VAL_EXTREME
    } val_mode_t;

    typedef struct packed {
        bit write_cfg;
        int size;
        int count;
        int first;
        int step;
        bit typed;
        int exp_total;
        int exp_min;
    } directed_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    elem_t                        element_value = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [mcar_pkg::TOTAL_W-1:0] nonneg_column_total;
    logic [mcar_pkg::MIN_W-1:0]   min_antidiagonal_sum;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [mcar_pkg::CFG_W-1:0]   matrix_size = mcar_pkg::CFG_W'(mcar_pkg::RESET_SIZE);

    // predictor state
    longint                     col_sum [MAX_N];
    bit                         col_neg [MAX_N];
    longint                     diag_sum [DIAG_N];
    longint                     column_total;
    logic [mcar_pkg::MIN_W-1:0] least_diag;
    int                         row_i;
    int                         col_i;
    logic [mcar_pkg::CFG_W-1:0] size_reg;

    reduce_result_t reduce_results [$];
    int             fail_count = 0;
    int             idle_cycles = 0;
    int             stall_left = 0;
    bit             sender_idles = 1'b0;
    bit             sink_stalls = 1'b0;

    directed_row_t directed_rows [0:5] = '{
        '{1'b0, 4, 16, 1, 0, 1'b1, 16, 1},
        '{1'b1, 1, 1, 32767, 0, 1'b1, 32767, 32767},
        '{1'b1, 0, 1, -32768, 0, 1'b1, 0, 32768},
        '{1'b1, 2, 4, -1, 3, 1'b0, 0, 0},
        '{1'b1, 3, 2, -7, 9, 1'b0, 0, 0},
        '{1'b1, 1, 1, 9, 0, 1'b1, 9, 9}
    };

    matrix_column_and_antidiagonal_reduce dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .element_value        (element_value),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .nonneg_column_total  (nonneg_column_total),
        .min_antidiagonal_sum (min_antidiagonal_sum),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .matrix_size          (matrix_size)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int active_size();
        if (size_reg == 0)
            return 1;
        if (size_reg > MAX_N)
            return MAX_N;
        return int'(size_reg);
    endfunction

    function automatic void restart_matrix();
        column_total = 0;
        least_diag   = '1;
        row_i        = 0;
        col_i        = 0;
    endfunction

    function automatic void fold_element(elem_t v);
        int                         n;
        int                         d;
        longint                     x;
        longint                     mag;
        logic [mcar_pkg::MIN_W-1:0] s;
        n   = active_size();
        x   = v;
        mag = (x < 0) ? -x : x;
        d   = row_i + col_i;
        if (row_i == 0)
        begin
            col_sum[col_i] = x;
            col_neg[col_i] = (x < 0);
        end
        else
        begin
            col_sum[col_i] += x;
            if (x < 0)
                col_neg[col_i] = 1'b1;
        end
        if (row_i == 0 || col_i == n - 1)
            diag_sum[d] = mag;
        else
            diag_sum[d] += mag;
        if (row_i == n - 1 && !col_neg[col_i])
            column_total += col_sum[col_i];
        if (col_i == 0 || row_i == n - 1)
        begin
            s = mcar_pkg::MIN_W'(diag_sum[d]);
            if (s < least_diag)
                least_diag = s;
        end
        if (row_i == n - 1 && col_i == n - 1)
        begin
            reduce_results.push_back('{mcar_pkg::TOTAL_W'(column_total), least_diag});
            restart_matrix();
        end
        else if (col_i == n - 1)
        begin
            col_i = 0;
            row_i = row_i + 1;
        end
        else
            col_i = col_i + 1;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic elem_t element_for(val_mode_t mode);
        elem_t v;
        int    k;
        case (mode)
            VAL_NONNEG:
                v = elem_t'($urandom_range(0, 32767));
            VAL_SPARSE_NEG:
                if ($urandom_range(0, 7) == 0)
                    v = elem_t'(-int'($urandom_range(1, 32768)));
                else
                    v = elem_t'($urandom_range(0, 32767));
            VAL_EXTREME:
            begin
                k = $urandom_range(0, 4);
                case (k)
                    0: v = 16'sh7fff;
                    1: v = 16'sh8000;
                    2: v = '0;
                    3: v = '1;
                    default: v = 16'sd1;
                endcase
            end
            default:
                v = elem_t'($urandom());
        endcase
        return v;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%s", msg);
    endfunction

    task automatic push_element(elem_t v);
        int gap;
        gap = 0;
        if (sender_idles && $urandom_range(0, 2) == 0)
            gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        element_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        fold_element(v);
    endtask

    task automatic settle_outputs();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (reduce_results.size() != 0);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic write_size(logic [mcar_pkg::CFG_W-1:0] sz);
        settle_outputs();
        cfg_valid   <= 1'b1;
        matrix_size <= sz;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        size_reg = sz;
        restart_matrix();
    endtask

    // receiver side stall pattern
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (sink_stalls && $urandom_range(0, 3) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= pick_gap();
        end
        else
            out_stall <= 1'b0;
    end

    // result beat checker
    always @(posedge clk)
    begin
        reduce_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (reduce_results.size() == 0)
                note_failure($sformatf("unexpected result beat: total %0d, min %0d",
                                       nonneg_column_total, min_antidiagonal_sum));
            else
            begin
                want = reduce_results.pop_front();
                if (nonneg_column_total !== want.total)
                    note_failure($sformatf("nonneg_column_total: expected %0d, got %0d",
                                           want.total, nonneg_column_total));
                if (min_antidiagonal_sum !== want.min_sum)
                    note_failure($sformatf("min_antidiagonal_sum: expected %0d, got %0d",
                                           want.min_sum, min_antidiagonal_sum));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        directed_row_t row;
        int            random_items;
        int            n;
        int            count;
        int            choice;
        int            i;
        val_mode_t     mode;

        size_reg = mcar_pkg::CFG_W'(mcar_pkg::RESET_SIZE);
        restart_matrix();
        random_items = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset size, extremes, size zero, ramp, abandoned matrix
        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            if (row.write_cfg)
                write_size(mcar_pkg::CFG_W'(row.size));
            for (i = 0; i < row.count; i++)
                push_element(elem_t'(row.first + i * row.step));
            if (row.typed)
                reduce_results[reduce_results.size() - 1] =
                    '{mcar_pkg::TOTAL_W'(row.exp_total), mcar_pkg::MIN_W'(row.exp_min)};
        end

        // partial matrix at a size above the maximum, abandoned by the next write
        sender_idles = 1'b1;
        sink_stalls  = 1'b1;
        write_size(mcar_pkg::CFG_W'(127));
        for (i = 0; i < OVERSIZE_ITEMS; i++)
            push_element(element_for(VAL_SPARSE_NEG));

        while (random_items < RANDOM_ITEMS)
        begin
            sender_idles = ($urandom_range(0, 3) != 0);
            sink_stalls  = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 24) == 0)
                settle_outputs();
            if (row_i != 0 || col_i != 0 || $urandom_range(0, 9) < 6)
            begin
                choice = $urandom_range(0, 99);
                if (choice < 70)
                    write_size(mcar_pkg::CFG_W'($urandom_range(1, 6)));
                else if (choice < 88)
                    write_size(mcar_pkg::CFG_W'($urandom_range(7, 16)));
                else if (choice < 94)
                    write_size('0);
                else if (choice < 97)
                    write_size(mcar_pkg::CFG_W'(MAX_N));
                else
                    write_size(mcar_pkg::CFG_W'($urandom_range(MAX_N + 1, 127)));
            end
            n     = active_size();
            count = n * n;
            // large sizes and a few small ones stop partway and get abandoned
            if (n > 16)
                count = $urandom_range(1, 150);
            else if (count > 1 && $urandom_range(0, 19) == 0)
                count = $urandom_range(1, count - 1);
            mode = val_mode_t'($urandom_range(0, 3));
            for (i = 0; i < count; i++)
                push_element(element_for(mode));
            random_items += count;
        end

        settle_outputs();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
